// ===== rtl/core/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg
// Types and constants shared by the dual pedal torque filter.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int TORQUE_W   = 16;
	localparam int READ_W     = 11;
	localparam int CAL_W      = 11;
	localparam int LIM_W      = 12;
	localparam int DIV_W      = 24;
	localparam int DVS_W      = 11;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_S1_REST      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_S1_FULL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_S2_REST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_S2_FULL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 3'd4;

	localparam logic [CAL_W-1:0] S1_REST_RST = 11'd120;
	localparam logic [CAL_W-1:0] S1_FULL_RST = 11'd752;
	localparam logic [CAL_W-1:0] S2_REST_RST = 11'd752;
	localparam logic [CAL_W-1:0] S2_FULL_RST = 11'd545;
	localparam logic [LIM_W-1:0] LIMIT_RST   = 12'd3100;

	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_MISMATCH = 2'd1;
	localparam logic [1:0] FAULT_ZERO     = 2'd2;

	typedef struct packed {
		logic [3:0] s1_hundreds;
		logic [6:0] s1_units;
		logic [3:0] s2_hundreds;
		logic [6:0] s2_units;
	} in_beat_t;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] filtered_torque;
		logic [1:0]                 fault_code;
		logic                       fault_latched;
		logic signed [TORQUE_W-1:0] pedal1_torque;
		logic signed [TORQUE_W-1:0] pedal2_torque;
	} out_beat_t;

	typedef struct packed {
		logic [CAL_W-1:0] s1_rest;
		logic [CAL_W-1:0] s1_full;
		logic [CAL_W-1:0] s2_rest;
		logic [CAL_W-1:0] s2_full;
		logic [LIM_W-1:0] torque_limit;
	} cfg_t;

	typedef struct packed {
		logic [CAL_W-1:0] off_mag;
		logic             off_neg;
		logic [DVS_W-1:0] dvs;
		logic             span_neg;
		logic             span_zero;
	} pre_t;

	typedef struct packed {
		logic [DIV_W-1:0] mag;
		logic [DVS_W-1:0] dvs;
		logic             neg;
		logic             span_zero;
	} map_job_t;

	typedef struct packed {
		map_job_t m1;
		map_job_t m2;
		logic     any_zero;
	} work_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MAP1,
		BK_MAP2,
		BK_MEAN,
		BK_AVG,
		BK_OUT
	} back_state_t;

endpackage

// ===== rtl/core/dpt_front.sv =====
// ----------------------------------------------------------------------------
// dpt_front
// Takes sample beats, rebuilds both readings, forms offsets and spans, and
// scales the offsets by the torque limit into divider jobs.
// ----------------------------------------------------------------------------
module dpt_front import dpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     sample_valid,
	output logic     sample_ready,
	input  in_beat_t sample,
	output logic     job_valid,
	input  logic     job_ready,
	output work_t    job
);

	localparam logic [READ_W-1:0] RADIX = 11'd100;

	logic [READ_W-1:0]  r1, r2;
	logic signed [CAL_W:0] d1, d2, sp1, sp2;
	pre_t pre1, pre2;
	pre_t pre1_s1, pre2_s1;
	logic zero_s1, v_s1;
	logic [CAL_W+LIM_W-1:0] p1, p2;
	logic take;

	function automatic logic [CAL_W-1:0] mag(input logic signed [CAL_W:0] d);
		logic [CAL_W:0] n;
		n = d[CAL_W] ? -d : d;
		return n[CAL_W-1:0];
	endfunction

	always_comb begin
		r1 = READ_W'(sample.s1_hundreds) * RADIX + READ_W'(sample.s1_units);
		r2 = READ_W'(sample.s2_hundreds) * RADIX + READ_W'(sample.s2_units);
		d1  = $signed({1'b0, r1}) - $signed({1'b0, cfg.s1_rest});
		sp1 = $signed({1'b0, cfg.s1_full}) - $signed({1'b0, cfg.s1_rest});
		d2  = $signed({1'b0, cfg.s2_rest}) - $signed({1'b0, r2});
		sp2 = $signed({1'b0, cfg.s2_rest}) - $signed({1'b0, cfg.s2_full});
		pre1.off_mag   = mag(d1);
		pre1.off_neg   = d1[CAL_W];
		pre1.dvs       = mag(sp1);
		pre1.span_neg  = sp1[CAL_W];
		pre1.span_zero = (sp1 == '0);
		pre2.off_mag   = mag(d2);
		pre2.off_neg   = d2[CAL_W];
		pre2.dvs       = mag(sp2);
		pre2.span_neg  = sp2[CAL_W];
		pre2.span_zero = (sp2 == '0);
	end

	assign job_valid    = v_s1;
	assign take         = sample_valid && sample_ready;
	assign sample_ready = !v_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (job_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pre1_s1 <= pre1;
			pre2_s1 <= pre2;
			zero_s1 <= (r1 == '0) || (r2 == '0);
		end
	end

	always_comb begin
		p1 = {{LIM_W{1'b0}}, pre1_s1.off_mag} * {{CAL_W{1'b0}}, cfg.torque_limit};
		p2 = {{LIM_W{1'b0}}, pre2_s1.off_mag} * {{CAL_W{1'b0}}, cfg.torque_limit};
		job.m1.mag       = DIV_W'(p1);
		job.m1.dvs       = pre1_s1.dvs;
		job.m1.neg       = pre1_s1.off_neg ^ pre1_s1.span_neg;
		job.m1.span_zero = pre1_s1.span_zero;
		job.m2.mag       = DIV_W'(p2);
		job.m2.dvs       = pre2_s1.dvs;
		job.m2.neg       = pre2_s1.off_neg ^ pre2_s1.span_neg;
		job.m2.span_zero = pre2_s1.span_zero;
		job.any_zero     = zero_s1;
	end

endmodule

// ===== rtl/core/dpt_queue.sv =====
// ----------------------------------------------------------------------------
// dpt_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module dpt_queue import dpt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/dpt_div.sv =====
// ----------------------------------------------------------------------------
// dpt_div
// Restoring serial divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module dpt_div import dpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	logic [DIV_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q, dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [DVS_W:0]       rem_sh, rem_sub;
	logic                 ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		ge      = (rem_sh >= {1'b0, dvs_q});
	end

	assign done = done_q;
	assign quot = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

endmodule

// ===== rtl/core/dpt_back.sv =====
// ----------------------------------------------------------------------------
// dpt_back
// Runs both pedal maps on the shared divider, averages the history with a
// reciprocal multiply, tracks the mismatch run and faults, and holds the
// result beat.
// ----------------------------------------------------------------------------
module dpt_back import dpt_pkg::*; #(
	parameter int HISTORY_DEPTH      = 4,
	parameter int MISMATCH_LIMIT     = 20,
	parameter int MISMATCH_TOLERANCE = 1600
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  work_t     job,
	output logic      result_valid,
	input  logic      result_ready,
	output out_beat_t result
);

	localparam int SUM_W  = TORQUE_W + $clog2(HISTORY_DEPTH);
	localparam int ZC_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int AVG_SH = SUM_W + $clog2(HISTORY_DEPTH);
	localparam longint unsigned AVG_RECIP_L =
		((64'd1 << AVG_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
	localparam logic [AVG_SH-1:0] AVG_RECIP = AVG_SH'(AVG_RECIP_L);

	back_state_t state_q, state_d;

	work_t job_q;
	logic signed [TORQUE_W-1:0] t1_q, t2_q, avg_q;
	logic signed [TORQUE_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [SUM_W-1:0]    sum_q, sum_nx;
	logic [SUM_W-1:0]           sum_mag;
	logic [SUM_W+AVG_SH-1:0]    avg_prod;
	logic [TORQUE_W-1:0]        avg_quot;
	logic [ZC_W-1:0]            zc_q, zc_nx;
	logic [7:0]                 run_q, run_nx;
	logic                       sticky_q;
	logic [1:0]                 code_q, code_nx;
	out_beat_t                  out_q;
	logic                       out_valid_q;

	logic signed [TORQUE_W:0]   tsum, tsum_adj, dif;
	logic [TORQUE_W:0]          adif;
	logic signed [TORQUE_W-1:0] mean, oldest;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dvd, div_quot;
	logic [DVS_W-1:0] div_dvs;

	function automatic logic signed [TORQUE_W-1:0] map_fin(input map_job_t m,
			input logic [DIV_W-1:0] q);
		logic signed [TORQUE_W-1:0] r;
		if (m.span_zero) begin
			r = '0;
		end else if (!m.neg) begin
			r = (q > DIV_W'(32767)) ? 16'sh7FFF : $signed(q[TORQUE_W-1:0]);
		end else begin
			r = (q > DIV_W'(32768)) ? 16'sh8000 : $signed(-q[TORQUE_W-1:0]);
		end
		return r;
	endfunction

	dpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		tsum     = $signed({t1_q[TORQUE_W-1], t1_q}) + $signed({t2_q[TORQUE_W-1], t2_q});
		tsum_adj = tsum + (tsum[TORQUE_W] ? 17'sd1 : 17'sd0);
		mean     = tsum_adj[TORQUE_W:1];
		dif      = $signed({t1_q[TORQUE_W-1], t1_q}) - $signed({t2_q[TORQUE_W-1], t2_q});
		adif     = dif[TORQUE_W] ? (TORQUE_W+1)'(-dif) : (TORQUE_W+1)'(dif);
		if (adif < (TORQUE_W+1)'(MISMATCH_TOLERANCE)) begin
			run_nx = '0;
		end else begin
			run_nx = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
		end
		if (run_nx >= 8'(MISMATCH_LIMIT)) begin
			code_nx = FAULT_MISMATCH;
		end else if (job_q.any_zero) begin
			code_nx = FAULT_ZERO;
		end else begin
			code_nx = FAULT_NONE;
		end
		oldest   = hist_q[HISTORY_DEPTH-1];
		sum_nx   = sum_q + SUM_W'(mean) - SUM_W'(oldest);
		zc_nx    = zc_q + ZC_W'(mean == '0) - ZC_W'(oldest == '0);
		sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		avg_prod = {{AVG_SH{1'b0}}, sum_mag} * {{SUM_W{1'b0}}, AVG_RECIP};
		avg_quot = avg_prod[AVG_SH+TORQUE_W-1:AVG_SH];
	end

	assign job_ready    = (state_q == BK_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = job.m1.mag;
		div_dvs   = job.m1.dvs;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					div_start = 1'b1;
					state_d   = BK_MAP1;
				end
			end
			BK_MAP1: begin
				div_dvd = job_q.m2.mag;
				div_dvs = job_q.m2.dvs;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = BK_MAP2;
				end
			end
			BK_MAP2: begin
				if (div_done) begin
					state_d = BK_MEAN;
				end
			end
			BK_MEAN: begin
				state_d = BK_AVG;
			end
			BK_AVG: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_valid_q || result_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			sticky_q    <= 1'b0;
			sum_q       <= '0;
			zc_q        <= ZC_W'(HISTORY_DEPTH);
			out_valid_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (state_q == BK_MEAN) begin
				run_q    <= run_nx;
				sticky_q <= sticky_q || (code_nx != FAULT_NONE);
				sum_q    <= sum_nx;
				zc_q     <= zc_nx;
				hist_q[0] <= mean;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
			if (state_q == BK_OUT && (!out_valid_q || result_ready)) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) begin
			job_q <= job;
		end
		if (state_q == BK_MAP1 && div_done) begin
			t1_q <= map_fin(job_q.m1, div_quot);
		end
		if (state_q == BK_MAP2 && div_done) begin
			t2_q <= map_fin(job_q.m2, div_quot);
		end
		if (state_q == BK_MEAN) begin
			code_q <= code_nx;
		end
		if (state_q == BK_AVG) begin
			if (zc_q != '0) begin
				avg_q <= '0;
			end else if (sum_q[SUM_W-1]) begin
				avg_q <= $signed(-avg_quot);
			end else begin
				avg_q <= $signed(avg_quot);
			end
		end
		if (state_q == BK_OUT && (!out_valid_q || result_ready)) begin
			out_q.filtered_torque <= avg_q;
			out_q.fault_code      <= code_q;
			out_q.fault_latched   <= sticky_q;
			out_q.pedal1_torque   <= t1_q;
			out_q.pedal2_torque   <= t2_q;
		end
	end

endmodule

// ===== rtl/core/dual_pedal_torque_filter.sv =====
// ----------------------------------------------------------------------------
// dual_pedal_torque_filter
// Dual pedal sensor plausibility check with a moving-average torque output.
//
//   channel   signals                              width
//   sample    sample_valid / sample_ready / sample in_beat_t (22 bit)
//   result    result_valid / result_ready / result out_beat_t (51 bit)
//   config    cfg_we / cfg_idx / cfg_wdata         3 bit index, 12 bit data
//
// Each beat runs both pedal maps through the shared serial divider (one quotient
// bit a cycle), then the mean, average and output states; the back takes the
// next beat only once it has returned to idle.
// Reset restores calibration defaults, clears history, run count and fault.
// A two-entry queue lets the front take samples while the back works, and
// the result register holds a beat while the next sample is taken.
// ----------------------------------------------------------------------------
module dual_pedal_torque_filter import dpt_pkg::*; #(
	parameter int HISTORY_DEPTH      = 4,
	parameter int MISMATCH_LIMIT     = 20,
	parameter int MISMATCH_TOLERANCE = 1600
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  in_beat_t              sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_beat_t             result
);

	cfg_t  cfg_q;
	logic  fj_valid, fj_ready, bj_valid, bj_ready;
	work_t fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.s1_rest      <= S1_REST_RST;
			cfg_q.s1_full      <= S1_FULL_RST;
			cfg_q.s2_rest      <= S2_REST_RST;
			cfg_q.s2_full      <= S2_FULL_RST;
			cfg_q.torque_limit <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_S1_REST:      cfg_q.s1_rest      <= cfg_wdata[CAL_W-1:0];
				CFG_S1_FULL:      cfg_q.s1_full      <= cfg_wdata[CAL_W-1:0];
				CFG_S2_REST:      cfg_q.s2_rest      <= cfg_wdata[CAL_W-1:0];
				CFG_S2_FULL:      cfg_q.s2_full      <= cfg_wdata[CAL_W-1:0];
				CFG_TORQUE_LIMIT: cfg_q.torque_limit <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	dpt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.job_valid    (fj_valid),
		.job_ready    (fj_ready),
		.job          (fj_data)
	);

	dpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj_data),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj_data)
	);

	dpt_back #(
		.HISTORY_DEPTH      (HISTORY_DEPTH),
		.MISMATCH_LIMIT     (MISMATCH_LIMIT),
		.MISMATCH_TOLERANCE (MISMATCH_TOLERANCE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (bj_valid),
		.job_ready    (bj_ready),
		.job          (bj_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
